// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the RTL. Every check is clocked and is
// disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge.
`define PLST_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an antecedent is followed by a consequent on the next clock.
`define PLST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/plst_pkg.sv =====
// ----------------------------------------------------------------------------
// plst_pkg
// Operation and status codes, cell commands and the control word that is
// broadcast along the cell row.
// ----------------------------------------------------------------------------
package plst_pkg;

	// Position width that covers every supported depth, up to 256.
	localparam int AT_W = 9;

	typedef enum logic [2:0] {
		OP_APPEND    = 3'd0,
		OP_PUSH_FRONT = 3'd1,
		OP_INSERT    = 3'd2,
		OP_POP_BACK  = 3'd3,
		OP_POP_FRONT = 3'd4,
		OP_REMOVE_AT = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CMD_HOLD   = 2'd0,
		CMD_LOAD   = 2'd1,
		CMD_INSERT = 2'd2,
		CMD_REMOVE = 2'd3
	} cell_cmd_t;

	typedef struct packed {
		cell_cmd_t         cmd;
		logic [AT_W-1:0]   at;
	} cell_ctl_t;

endpackage

// ===== rtl/core/plst_req_if.sv =====
// ----------------------------------------------------------------------------
// plst_req_if
// Request channel: one operation word with its value and position.
// ----------------------------------------------------------------------------
interface plst_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  operation;
	logic [31:0] value;
	logic [3:0]  position;

	modport source (output valid, output operation, output value, output position,
		input ready);
	modport sink (input valid, input operation, input value, input position,
		output ready);
endinterface

// ===== rtl/core/plst_rsp_if.sv =====
// ----------------------------------------------------------------------------
// plst_rsp_if
// Response channel: status, new length and front value of one operation.
// ----------------------------------------------------------------------------
interface plst_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [4:0]  length;
	logic [31:0] front_value;

	modport source (output valid, output status, output length, output front_value,
		input ready);
	modport sink (input valid, input status, input length, input front_value,
		output ready);
endinterface

// ===== rtl/core/positional_list_store.sv =====
// ----------------------------------------------------------------------------
// positional_list_store
// Bounded ordered list with append, push front, insert, pop back, pop front
// and remove at a position, built as a row of shifting cells.
// ----------------------------------------------------------------------------
// The store holds up to DEPTH elements in a row of cells, front at cell 0.
// Each request word carries one operation; every cell looks at the same
// broadcast command and either holds, loads the new value, or takes its
// left or right neighbor's element, so an insert or removal at any position
// is done by every cell on the same clock edge. A request is
// accepted whenever the response register is empty or being drained in the
// same cycle, and its response word is presented on the next cycle, so one
// operation per clock is sustained while the consumer keeps ready high. The
// response gives a status (done, position out of range, full, empty), the
// length after the operation and the front element, which is zero when the
// list is empty. A failed operation changes nothing. Insert accepts
// positions below the current length only; remove reports empty before it
// checks the position. Operation codes six and seven change nothing and
// report done. Values wider than DATA_WIDTH are truncated on entry, and the
// front value is zero-extended or truncated to 32 bits. No clearing pass
// follows reset: only the length and response register are cleared, cell
// contents are never read before they are written.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module positional_list_store
	import plst_pkg::*;
#(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic  clk,
	input  logic  arst_n,
	plst_req_if.sink   req,
	plst_rsp_if.source rsp
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

	// length and response register
	logic [CW-1:0] count_q;
	logic          rsp_valid_q;
	status_t       status_q;

	// decode of the current request
	logic          accept;
	logic          full;
	logic          empty;
	logic [AT_W-1:0] pos_ext;
	logic [AT_W-1:0] cnt_ext;
	cell_ctl_t     ctl_n;
	cell_ctl_t     ctl;
	status_t       status_n;
	logic [CW-1:0] count_n;

	// cell row
	logic [DATA_WIDTH-1:0] value_w;
	logic [DATA_WIDTH-1:0] cell_data [DEPTH];
	logic [63:0]           front_wide;

	// take a new word whenever the response slot is free or draining now
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	assign full    = (count_q == FULL_COUNT);
	assign empty   = (count_q == '0);
	assign pos_ext = AT_W'(req.position);
	assign cnt_ext = AT_W'(count_q);
	assign value_w = DATA_WIDTH'(req.value);

	always_comb begin
		ctl_n.cmd = CMD_HOLD;
		ctl_n.at  = cnt_ext;
		status_n  = ST_DONE;
		count_n   = count_q;
		case (op_t'(req.operation))
			OP_APPEND: begin
				if (full) status_n = ST_FULL;
				else begin
					// write straight into the first free slot
					ctl_n.cmd = CMD_LOAD;
					ctl_n.at  = cnt_ext;
					count_n   = count_q + CW'(1);
				end
			end
			OP_PUSH_FRONT: begin
				if (full) status_n = ST_FULL;
				else begin
					ctl_n.cmd = CMD_INSERT;
					ctl_n.at  = '0;
					count_n   = count_q + CW'(1);
				end
			end
			OP_INSERT: begin
				// range check wins over the full check
				if (pos_ext >= cnt_ext) status_n = ST_RANGE;
				else if (full) status_n = ST_FULL;
				else begin
					ctl_n.cmd = CMD_INSERT;
					ctl_n.at  = pos_ext;
					count_n   = count_q + CW'(1);
				end
			end
			OP_POP_BACK: begin
				// dropping the last element only shortens the list
				if (empty) status_n = ST_EMPTY;
				else count_n = count_q - CW'(1);
			end
			OP_POP_FRONT: begin
				if (empty) status_n = ST_EMPTY;
				else begin
					ctl_n.cmd = CMD_REMOVE;
					ctl_n.at  = '0;
					count_n   = count_q - CW'(1);
				end
			end
			OP_REMOVE_AT: begin
				if (empty) status_n = ST_EMPTY;
				else if (pos_ext >= cnt_ext) status_n = ST_RANGE;
				else begin
					ctl_n.cmd = CMD_REMOVE;
					ctl_n.at  = pos_ext;
					count_n   = count_q - CW'(1);
				end
			end
			default: ;
		endcase
	end

	// cells move only on an accepted word
	always_comb begin
		ctl = ctl_n;
		if (!accept) ctl.cmd = CMD_HOLD;
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] left_w;
		logic [DATA_WIDTH-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_left
			assign left_w = cell_data[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_right
			assign right_w = cell_data[i+1];
		end

		plst_cell #(
			.IDX        (i),
			.DATA_WIDTH (DATA_WIDTH)
		) u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.value (value_w),
			.left  (left_w),
			.right (right_w),
			.data  (cell_data[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
			status_q    <= ST_DONE;
		end else begin
			if (accept) begin
				count_q     <= count_n;
				status_q    <= status_n;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// length and front come from the live state: it changes only together
	// with a new response word, so a waiting word holds steady
	assign front_wide      = 64'(cell_data[0]);
	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = status_q;
	assign rsp.length      = 5'(count_q);
	assign rsp.front_value = empty ? 32'd0 : front_wide[31:0];

	// ------------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------------
	`PLST_ASSERT(a_count_bound, clk, arst_n, count_q <= FULL_COUNT,
		"length beyond capacity")
	`PLST_ASSERT_NEXT(a_fail_keeps, clk, arst_n, accept && status_n != ST_DONE,
		count_q == $past(count_q), "failed operation changed the length")
	`PLST_ASSERT_NEXT(a_remove_shrinks, clk, arst_n, accept && ctl_n.cmd == CMD_REMOVE,
		count_q == $past(count_q) - CW'(1), "removal did not shorten the list")
	`PLST_ASSERT_NEXT(a_rsp_follows, clk, arst_n, accept, rsp.valid,
		"accepted word gave no response")

endmodule

// ===== rtl/core/plst_cell.sv =====
// ----------------------------------------------------------------------------
// plst_cell
// One slot of the list. Holds its element, loads a new value, or takes the
// element of its left or right neighbor when the row shifts.
// ----------------------------------------------------------------------------
module plst_cell
	import plst_pkg::*;
#(
	parameter int IDX        = 0,
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  cell_ctl_t             ctl,
	input  logic [DATA_WIDTH-1:0] value,
	input  logic [DATA_WIDTH-1:0] left,
	input  logic [DATA_WIDTH-1:0] right,
	output logic [DATA_WIDTH-1:0] data
);

	localparam logic [AT_W-1:0] MY_IDX = AT_W'(IDX);

	logic [DATA_WIDTH-1:0] data_q;
	logic [DATA_WIDTH-1:0] data_n;

	always_comb begin
		data_n = data_q;
		case (ctl.cmd)
			CMD_LOAD: begin
				if (MY_IDX == ctl.at) data_n = value;
			end
			CMD_INSERT: begin
				// open a gap: slots above the position move up
				if (MY_IDX > ctl.at) data_n = left;
				else if (MY_IDX == ctl.at) data_n = value;
			end
			CMD_REMOVE: begin
				// close the gap: slots from the position on move down
				if (MY_IDX >= ctl.at) data_n = right;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_n;
	end

	assign data = data_q;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for positional_list_store. A scoreboard tracks its own
// copy of the list and works out the status, length and front element for
// each accepted request word. Each response word is checked against the
// oldest prediction. Directed words cover empty, full and out-of-range
// cases. Random words then swing the list between empty and full, under
// several idle and stall patterns and one long response hold-off.
// ----------------------------------------------------------------------------
module testbench;
	import plst_pkg::*;

	localparam int LIST_DEPTH = 16;
	// Codes six and seven are not operations; the store must leave the list alone.
	localparam logic [2:0] CODE_SPARE_LO = 3'd6;
	localparam logic [2:0] CODE_SPARE_HI = 3'd7;
	localparam int HOLD_OFF_CYCLES = 80;
	localparam int RANDOM_PER_PHASE = 110;
	localparam int TAIL_CYCLES = 4;

	typedef struct {
		status_t     status;
		logic [4:0]  length;
		logic [31:0] front;
	} list_outcome_t;

	// Scoreboard: keeps a private copy of the list, predicts the response to
	// every accepted request word and checks response words in order.
	class list_tracker;
		logic [31:0]   cells [LIST_DEPTH];
		int unsigned   count;
		list_outcome_t awaited [$];
		int unsigned   requests;
		int unsigned   checked;
		int unsigned   mismatches;
		int unsigned   status_seen [4];

		function new();
			count = 0;
			requests = 0;
			checked = 0;
			mismatches = 0;
			foreach (status_seen[i])
				status_seen[i] = 0;
		endfunction

		function void open_gap(int unsigned at, logic [31:0] v);
			for (int unsigned i = count; i > at; i--)
				cells[i] = cells[i - 1];
			cells[at] = v;
			count++;
		endfunction

		function void close_gap(int unsigned at);
			for (int unsigned i = at; i + 1 < count; i++)
				cells[i] = cells[i + 1];
			count--;
		endfunction

		function void note_request(logic [2:0] code, logic [31:0] v, logic [3:0] pos);
			list_outcome_t outcome;
			status_t       st;
			st = ST_DONE;
			case (code)
				OP_APPEND: begin
					if (count >= LIST_DEPTH)
						st = ST_FULL;
					else begin
						cells[count] = v;
						count++;
					end
				end
				OP_PUSH_FRONT: begin
					if (count >= LIST_DEPTH)
						st = ST_FULL;
					else
						open_gap(0, v);
				end
				OP_INSERT: begin
					if (pos >= count)
						st = ST_RANGE;
					else if (count >= LIST_DEPTH)
						st = ST_FULL;
					else
						open_gap(pos, v);
				end
				OP_POP_BACK: begin
					if (count == 0)
						st = ST_EMPTY;
					else
						count--;
				end
				OP_POP_FRONT: begin
					if (count == 0)
						st = ST_EMPTY;
					else
						close_gap(0);
				end
				OP_REMOVE_AT: begin
					if (count == 0)
						st = ST_EMPTY;
					else if (pos >= count)
						st = ST_RANGE;
					else
						close_gap(pos);
				end
				default: begin
				end
			endcase
			outcome.status = st;
			outcome.length = count[4:0];
			outcome.front = (count == 0) ? 32'd0 : cells[0];
			awaited.push_back(outcome);
			requests++;
			status_seen[st]++;
		endfunction

		function void check_response(logic [1:0] status, logic [4:0] length,
			logic [31:0] front);
			list_outcome_t want;
			if (awaited.size() == 0) begin
				$error("response with no request outstanding: status %0d length %0d front %h",
					status, length, front);
				mismatches++;
				return;
			end
			want = awaited.pop_front();
			checked++;
			if (status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, status);
				mismatches++;
			end
			if (length !== want.length) begin
				$error("length: expected %0d, got %0d", want.length, length);
				mismatches++;
			end
			if (front !== want.front) begin
				$error("front_value: expected %h, got %h", want.front, front);
				mismatches++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	plst_req_if req ();
	plst_rsp_if rsp ();

	list_tracker tracker = new();

	// Idle and stall odds in percent, and a request for a long response hold-off.
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned hold_off_asked = 0;

	positional_list_store #(
		.DEPTH      (LIST_DEPTH),
		.DATA_WIDTH (32)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: a healthy run ends long before this.
	initial begin
		#2ms;
		$display("testbench: FAIL");
		$finish;
	end

	// Response side: check every accepted word, then pick ready for the next
	// edge. A hold-off request drops ready for a fixed stretch, counted here.
	initial begin : response_side
		int unsigned hold_left;
		int unsigned holds_served;
		hold_left = 0;
		holds_served = 0;
		rsp.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (!arst_n) begin
				rsp.ready <= 1'b0;
			end else begin
				if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
					tracker.check_response(rsp.status, rsp.length, rsp.front_value);
				if (holds_served != hold_off_asked) begin
					holds_served = hold_off_asked;
					hold_left = HOLD_OFF_CYCLES;
				end
				if (hold_left > 0) begin
					hold_left--;
					rsp.ready <= 1'b0;
				end else begin
					rsp.ready <= ($urandom_range(99) >= stall_pct);
				end
			end
		end
	end

	// Offer one request word, idling first at the current odds, and hold it
	// until the store takes it. Called right after a rising edge.
	task automatic send_request(logic [2:0] code, logic [31:0] v, logic [3:0] pos);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.operation <= code;
		req.value <= v;
		req.position <= pos;
		@(posedge clk);
		while (req.ready !== 1'b1)
			@(posedge clk);
		tracker.note_request(code, v, pos);
	endtask

	// Boundary words: empty store, unused codes, insert and remove range
	// limits, then fill the list and hit it while full.
	task automatic run_directed();
		send_request(OP_POP_BACK, 32'hFFFF_FFFF, 4'd15);
		send_request(OP_POP_FRONT, 32'h0, 4'd0);
		send_request(OP_REMOVE_AT, 32'h0, 4'd0);
		// any insert on an empty list is out of range
		send_request(OP_INSERT, 32'h1234_5678, 4'd0);
		send_request(CODE_SPARE_LO, 32'h0, 4'd0);
		send_request(CODE_SPARE_HI, 32'hFFFF_FFFF, 4'd15);
		send_request(OP_APPEND, 32'h0000_0000, 4'd15);
		send_request(OP_APPEND, 32'hFFFF_FFFF, 4'd0);
		send_request(OP_PUSH_FRONT, 32'h8000_0001, 4'd7);
		send_request(OP_INSERT, 32'h5A5A_5A5A, 4'd0);
		// last valid insert slot places the value there, it does not append
		send_request(OP_INSERT, 32'hA5A5_A5A5, 4'd3);
		send_request(OP_INSERT, 32'hDEAD_BEEF, 4'd5);
		send_request(OP_REMOVE_AT, 32'hFFFF_FFFF, 4'd15);
		send_request(OP_REMOVE_AT, 32'h0, 4'd4);
		send_request(CODE_SPARE_HI, 32'h0, 4'd0);
		// fill through inserts at random valid slots
		while (tracker.count < LIST_DEPTH)
			send_request(OP_INSERT, $urandom, 4'($urandom_range(tracker.count - 1)));
		send_request(OP_APPEND, 32'h1111_1111, 4'd0);
		send_request(OP_PUSH_FRONT, 32'h2222_2222, 4'd0);
		send_request(OP_INSERT, 32'h3333_3333, 4'd15);
		send_request(OP_REMOVE_AT, 32'h0, 4'd15);
		send_request(OP_POP_FRONT, 32'h0, 4'd0);
		send_request(OP_POP_BACK, 32'h0, 4'd0);
	endtask

	// Random words that drift the list toward full, then toward empty, so
	// every length and both boundaries are visited over and over.
	task automatic run_random(int unsigned n);
		bit          growing;
		int unsigned pick;
		int unsigned len;
		logic [2:0]  code;
		logic [31:0] v;
		logic [3:0]  pos;
		growing = 1'b1;
		repeat (n) begin
			len = tracker.count;
			if (len == LIST_DEPTH)
				growing = 1'b0;
			else if (len == 0)
				growing = 1'b1;
			else if ($urandom_range(19) == 0)
				growing = !growing;

			pick = $urandom_range(99);
			if (pick < 4)
				code = $urandom_range(1) ? CODE_SPARE_HI : CODE_SPARE_LO;
			else if (pick < (growing ? 74 : 30))
				code = 3'($urandom_range(OP_INSERT, OP_APPEND));
			else
				code = 3'($urandom_range(OP_REMOVE_AT, OP_POP_BACK));

			case ($urandom_range(7))
				0: v = 32'h0000_0000;
				1: v = 32'hFFFF_FFFF;
				default: v = $urandom;
			endcase

			pick = $urandom_range(9);
			if (pick == 0)
				pos = (len < LIST_DEPTH) ? 4'(len) : 4'd15;
			else if (pick < 3 || len == 0)
				pos = 4'($urandom_range(15));
			else
				pos = 4'($urandom_range(len - 1));

			send_request(code, v, pos);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.operation = OP_APPEND;
		req.value = 32'h0;
		req.position = 4'd0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Light idling on both sides while the boundaries are walked.
		send_idle_pct = 13;
		stall_pct = 13;
		run_directed();

		// Back to back, no idling anywhere.
		send_idle_pct = 0;
		stall_pct = 0;
		run_random(RANDOM_PER_PHASE);

		// Sparse requests.
		send_idle_pct = 80;
		stall_pct = 0;
		run_random(RANDOM_PER_PHASE);

		// Slow consumer.
		send_idle_pct = 0;
		stall_pct = 80;
		run_random(RANDOM_PER_PHASE);

		// Both sides occasionally idle.
		send_idle_pct = 13;
		stall_pct = 13;
		run_random(RANDOM_PER_PHASE);

		// Long hold-off on the response side while requests keep coming, so
		// the store fills its response slot and stalls its input.
		send_idle_pct = 0;
		stall_pct = 0;
		hold_off_asked++;
		run_random(RANDOM_PER_PHASE);

		// Drop valid, drain what is still in flight, then give the store a
		// few more cycles to show any stray response word.
		req.valid <= 1'b0;
		while (tracker.awaited.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("summary: %0d operations sent, %0d responses checked, %0d mismatches",
			tracker.requests, tracker.checked, tracker.mismatches);
		$display("summary: outcomes done %0d, out of range %0d, full %0d, empty %0d",
			tracker.status_seen[ST_DONE], tracker.status_seen[ST_RANGE],
			tracker.status_seen[ST_FULL], tracker.status_seen[ST_EMPTY]);
		if (tracker.mismatches == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
